// ===== sv/pte_pkg.sv =====
`default_nettype none

package pte_pkg;

  localparam int MAX_PACKET_BYTES_DEF = 65536;

  localparam int OFF_W  = 17;
  localparam int PTS_W  = 33;
  localparam int EXT_W  = 48;
  localparam int REL_W  = 47;
  localparam int NS_W   = 63;

  // rel_ticks / 9 by long division, one byte of the dividend per stage
  localparam int DIV_STAGES = 6;
  localparam int DIV_W      = 8 * DIV_STAGES;
  localparam int QUO_W      = 44;
  localparam int FRAC_W     = 17;
  localparam int PROD_W     = 61;
  localparam int TICK_NS_NUM = 100000;
  localparam int DIV9_RECIP  = 57;
  localparam int DIV9_SHIFT  = 9;
  localparam int DIVISOR     = 9;

  localparam int MID_DEPTH = 4;
  localparam int MID_CNT_W = $clog2(MID_DEPTH + 1);
  localparam int OUT_DEPTH = 16;
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  localparam logic [REL_W-1:0] REL_MAX = '1;

  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic       stream_sel;
    logic [7:0] data_byte;
    logic       packet_end;
  } in_item_t;

  typedef struct packed {
    logic              forwarded;
    logic [OFF_W-1:0]  payload_offset;
    logic [OFF_W-1:0]  payload_length;
    logic              has_timestamp;
    logic [REL_W-1:0]  rel_ticks;
    logic [NS_W-1:0]   time_ns;
    logic              too_long;
  } out_item_t;

  // classified packet (or clear) handed from front to back
  typedef struct packed {
    logic             clr;
    logic             sel;
    logic             fwd;
    logic             ts;
    logic             too_long;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] plen;
    logic [PTS_W-1:0] raw;
  } pkt_t;

  typedef struct packed {
    logic             fwd;
    logic             ts;
    logic             too_long;
    logic [OFF_W-1:0] off;
    logic [OFF_W-1:0] plen;
  } meta_t;

  // one radix-16 step of division by 9: returns {quotient digit, remainder}
  function automatic logic [7:0] div9_nib(input logic [3:0] rem, input logic [3:0] nib);
    logic [7:0]  v;
    logic [13:0] p;
    logic [3:0]  q;
    logic [7:0]  back;
    v    = {rem, nib};
    p    = 14'(v) * 14'(DIV9_RECIP);
    q    = 4'(p >> DIV9_SHIFT);
    back = 8'(q) * 8'(DIVISOR);
    return {q, 4'(v - back)};
  endfunction

  // floor(r * 100000 / 9) for a remainder of division by 9
  function automatic logic [FRAC_W-1:0] frac9(input logic [3:0] r);
    logic [FRAC_W-1:0] f;
    unique case (r)
      4'd0:    f = FRAC_W'(0);
      4'd1:    f = FRAC_W'(11111);
      4'd2:    f = FRAC_W'(22222);
      4'd3:    f = FRAC_W'(33333);
      4'd4:    f = FRAC_W'(44444);
      4'd5:    f = FRAC_W'(55555);
      4'd6:    f = FRAC_W'(66666);
      4'd7:    f = FRAC_W'(77777);
      4'd8:    f = FRAC_W'(88888);
      default: f = FRAC_W'(0);
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

// ===== sv/pte_queue.sv =====
`default_nettype none

module pte_queue #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         push,
  input  wire logic [Width-1:0]             wdata,
  input  wire logic                         pop,
  output logic      [Width-1:0]             rdata,
  output logic      [$clog2(Depth+1)-1:0]   count
);

  localparam int AW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);
  localparam logic [AW-1:0] LAST = AW'(Depth - 1);

  logic [Width-1:0] mem [0:Depth-1];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;

  assign rdata = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== sv/pte_front.sv =====
`default_nettype none

module pte_front #(
  parameter int MAX_PACKET_BYTES = pte_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              take,
  input  wire pte_pkg::in_item_t item,
  output logic                   valid,
  output pte_pkg::pkt_t          entry
);

  import pte_pkg::*;

  localparam int CNT_W    = $clog2(MAX_PACKET_BYTES + 1);
  localparam int OFF9_W   = 9;
  localparam int LEN_W    = (CNT_W > OFF9_W) ? CNT_W : OFF9_W;
  localparam int HDR_KEEP = 14;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PACKET_BYTES);

  localparam logic [7:0] SID_BC = 8'hBC;
  localparam logic [7:0] SID_BE = 8'hBE;
  localparam logic [7:0] SID_BF = 8'hBF;
  localparam logic [7:0] SID_F0 = 8'hF0;
  localparam logic [7:0] SID_F1 = 8'hF1;
  localparam logic [7:0] SID_F2 = 8'hF2;
  localparam logic [7:0] SID_FF = 8'hFF;
  localparam logic [1:0] MPEG2_MARK = 2'b10;
  localparam logic [3:0] PTS_NIB_A  = 4'h2;
  localparam logic [3:0] PTS_NIB_B  = 4'h3;
  localparam logic [7:0] START_LAST = 8'h01;

  logic [CNT_W-1:0] pos;
  logic             ovf;
  logic [7:0]       hdr [0:HDR_KEEP-1];

  logic [7:0]       hv [0:HDR_KEEP-1];
  logic             at_max;
  logic [CNT_W-1:0] len_next;

  logic [CNT_W-1:0] cap_len;
  logic             cap_ovf;
  logic             cap_clr;
  logic             cap_sel;
  logic [7:0]       cap_hdr [0:HDR_KEEP-1];

  // header as it stands including the byte being taken
  always_comb begin
    for (int i = 0; i < HDR_KEEP; i++) begin
      hv[i] = (pos == CNT_W'(i)) ? item.data_byte : hdr[i];
    end
  end

  assign at_max   = (pos == MAX_CNT);
  assign len_next = at_max ? pos : pos + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      ovf   <= 1'b0;
      valid <= 1'b0;
    end else begin
      valid <= take && (item.cmd == CMD_CLEAR || item.packet_end);
      if (take) begin
        if (item.cmd == CMD_CLEAR || item.packet_end) begin
          pos <= '0;
          ovf <= 1'b0;
        end else if (!at_max) begin
          pos <= pos + CNT_W'(1);
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && item.cmd == CMD_DATA && pos < CNT_W'(HDR_KEEP)) begin
      hdr[pos[3:0]] <= item.data_byte;
    end
    if (take && (item.cmd == CMD_CLEAR || item.packet_end)) begin
      cap_clr <= (item.cmd == CMD_CLEAR);
      cap_sel <= item.stream_sel;
      cap_len <= len_next;
      cap_ovf <= ovf | at_max;
      for (int i = 0; i < HDR_KEEP; i++) begin
        cap_hdr[i] <= hv[i];
      end
    end
  end

  // classify the captured packet
  logic             start_ok;
  logic             mpeg2;
  logic             sid_bad;
  logic             have;
  logic [LEN_W-1:0] len_x;
  logic [LEN_W-1:0] off9;
  logic [LEN_W-1:0] off;
  logic [LEN_W-1:0] plen;

  always_comb begin
    len_x    = LEN_W'(cap_len);
    off9     = LEN_W'(OFF9_W) + LEN_W'(cap_hdr[8]);
    start_ok = (cap_len >= CNT_W'(3)) && (cap_hdr[0] == 8'h00) && (cap_hdr[1] == 8'h00)
               && (cap_hdr[2] == START_LAST);
    mpeg2    = (cap_hdr[6][7:6] == MPEG2_MARK);
    sid_bad  = (cap_hdr[3] == SID_BC) || (cap_hdr[3] == SID_BE) || (cap_hdr[3] == SID_BF) ||
               (cap_hdr[3] == SID_F0) || (cap_hdr[3] == SID_F1) || (cap_hdr[3] == SID_F2) ||
               (cap_hdr[3] == SID_FF);

    priority if (cap_len < CNT_W'(9) || !start_ok) begin
      off = '0;
    end else if (!mpeg2) begin
      off = LEN_W'(6);
    end else begin
      off = (off9 > len_x) ? len_x : off9;
    end
    plen = len_x - off;

    have = (cap_len >= CNT_W'(HDR_KEEP)) && start_ok && !sid_bad && mpeg2 &&
           (cap_hdr[7][7:6] != 2'b00) &&
           ((cap_hdr[9][7:4] == PTS_NIB_A) || (cap_hdr[9][7:4] == PTS_NIB_B));

    entry.clr      = cap_clr;
    entry.sel      = cap_sel;
    entry.fwd      = (plen != '0);
    entry.ts       = (plen != '0) && have;
    entry.too_long = cap_ovf;
    entry.off      = OFF_W'(off);
    entry.plen     = OFF_W'(plen);
    entry.raw      = {cap_hdr[9][3:1], cap_hdr[10], cap_hdr[11][7:1], cap_hdr[12],
                      cap_hdr[13][7:1]};
  end

endmodule

`default_nettype wire

// ===== sv/pte_unwrap.sv =====
`default_nettype none

module pte_unwrap (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          issue,
  input  wire pte_pkg::pkt_t                 entry,
  output logic                               valid,
  output logic [pte_pkg::REL_W-1:0]          rel,
  output pte_pkg::meta_t                     meta
);

  import pte_pkg::*;

  localparam int PAD_W = EXT_W - PTS_W;

  logic [1:0]       last_valid;
  logic [PTS_W-1:0] last_raw [0:1];
  logic [EXT_W-1:0] ext      [0:1];
  logic             base_valid;
  logic [EXT_W-1:0] base;

  logic [PTS_W:0]   diff;
  logic             neg;
  logic [EXT_W-1:0] step;
  logic [EXT_W-1:0] ext_new;
  logic [EXT_W-1:0] base_use;
  meta_t            m_in;

  logic             a_valid;
  logic [EXT_W-1:0] a_ext;
  logic [EXT_W-1:0] a_base;
  meta_t            a_meta;

  logic [EXT_W:0]   r;
  logic [REL_W-1:0] rel_next;

  // a jump of exactly half the range counts as forward when the raw value dropped
  always_comb begin
    diff     = {1'b0, entry.raw} - {1'b0, last_raw[entry.sel]};
    neg      = diff[PTS_W-1] & ~(diff[PTS_W] & (diff[PTS_W-2:0] == '0));
    step     = neg ? {{PAD_W{1'b1}}, diff[PTS_W-1:0]} : {{PAD_W{1'b0}}, diff[PTS_W-1:0]};
    ext_new  = last_valid[entry.sel] ? ext[entry.sel] + step : {{PAD_W{1'b0}}, entry.raw};
    base_use = base_valid ? base : ext_new;
    m_in.fwd      = entry.fwd;
    m_in.ts       = entry.ts;
    m_in.too_long = entry.too_long;
    m_in.off      = entry.off;
    m_in.plen     = entry.plen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_valid <= '0;
      base_valid <= 1'b0;
      a_valid    <= 1'b0;
      valid      <= 1'b0;
    end else begin
      a_valid <= issue && !entry.clr;
      valid   <= a_valid;
      if (issue) begin
        if (entry.clr) begin
          last_valid <= '0;
          base_valid <= 1'b0;
        end else if (entry.ts) begin
          last_valid[entry.sel] <= 1'b1;
          base_valid            <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue && !entry.clr && entry.ts) begin
      last_raw[entry.sel] <= entry.raw;
      ext[entry.sel]      <= ext_new;
      if (!base_valid) begin
        base <= ext_new;
      end
    end
    a_ext  <= ext_new;
    a_base <= base_use;
    a_meta <= m_in;
    rel    <= rel_next;
    meta   <= a_meta;
  end

  always_comb begin
    r = {a_ext[EXT_W-1], a_ext} - {a_base[EXT_W-1], a_base};
    priority if (!a_meta.ts || r[EXT_W]) begin
      rel_next = '0;
    end else if (r[EXT_W-1]) begin
      rel_next = REL_MAX;
    end else begin
      rel_next = r[REL_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/pte_scale.sv =====
`default_nettype none

module pte_scale (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [pte_pkg::REL_W-1:0] rel,
  input  wire pte_pkg::meta_t            meta,
  output logic                           done,
  output pte_pkg::out_item_t             result
);

  import pte_pkg::*;

  logic             vld [1:DIV_STAGES];
  logic [DIV_W-1:0] dw  [1:DIV_STAGES];
  logic [3:0]       rm  [1:DIV_STAGES];
  logic [REL_W-1:0] rl  [1:DIV_STAGES];
  meta_t            mt  [1:DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    logic             v_in;
    logic [DIV_W-1:0] w_in;
    logic [3:0]       r_in;
    logic [REL_W-1:0] rel_in;
    meta_t            m_in;
    logic [7:0]       st_hi;
    logic [7:0]       st_lo;
    logic [DIV_W-1:0] w_out;

    if (s == 0) begin : g_first
      assign v_in   = start;
      assign w_in   = {{(DIV_W-REL_W){1'b0}}, rel};
      assign r_in   = '0;
      assign rel_in = rel;
      assign m_in   = meta;
    end else begin : g_rest
      assign v_in   = vld[s];
      assign w_in   = dw[s];
      assign r_in   = rm[s];
      assign rel_in = rl[s];
      assign m_in   = mt[s];
    end

    // dividend byte is replaced in place by its quotient digits
    always_comb begin
      st_hi = div9_nib(r_in, w_in[DIV_W-1-8*s -: 4]);
      st_lo = div9_nib(st_hi[3:0], w_in[DIV_W-5-8*s -: 4]);
      w_out = w_in;
      w_out[DIV_W-1-8*s -: 8] = {st_hi[7:4], st_lo[7:4]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else begin
        vld[s+1] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      dw[s+1] <= w_out;
      rm[s+1] <= st_lo[3:0];
      rl[s+1] <= rel_in;
      mt[s+1] <= m_in;
    end
  end

  logic              m_valid;
  logic [PROD_W-1:0] m_prod;
  logic [FRAC_W-1:0] m_frac;
  logic [REL_W-1:0]  m_rel;
  meta_t             m_meta;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= vld[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    m_prod <= PROD_W'(dw[DIV_STAGES][QUO_W-1:0]) * PROD_W'(TICK_NS_NUM);
    m_frac <= frac9(rm[DIV_STAGES]);
    m_rel  <= rl[DIV_STAGES];
    m_meta <= mt[DIV_STAGES];
  end

  assign done = m_valid;

  always_comb begin
    result.forwarded      = m_meta.fwd;
    result.payload_offset = m_meta.off;
    result.payload_length = m_meta.plen;
    result.has_timestamp  = m_meta.ts;
    result.rel_ticks      = m_rel;
    result.time_ns        = NS_W'(m_prod) + NS_W'(m_frac);
    result.too_long       = m_meta.too_long;
  end

endmodule

`default_nettype wire

// ===== sv/pes_timestamp_extract_unwrap_top.sv =====
// PES timestamp extractor and unwrapper.
// Input queue port: push/full with item {cmd, stream_sel, data_byte, packet_end}.
// One packet byte per item; packet_end marks the last byte. A clear command
// drops any partial packet and forgets both streams' PTS and the baseline.
// Output queue port: empty/pop with result; one result per packet end, none
// for other bytes or for clear. The oldest result sits on result while empty
// is low and leaves on pop.
// Throughput: one item per cycle sustained while full is low. The front captures the header and
// classifies the packet, then hands it through a 4-entry queue to the back,
// which unwraps the PTS, divides by 9 over six stages and scales to ns in a
// multiply stage, all pipelined so that packets overlap.
// If the receiver stalls, results collect in a 16-entry output queue; the
// back stops issuing once that queue and its pipeline would overflow, and
// full rises when the middle queue holds three entries, one short of its depth.
// Reset (rst, synchronous) empties both queues, zeroes the byte count and
// clears all timestamp state.
`default_nettype none

module pes_timestamp_extract_unwrap_top #(
  parameter int MAX_PACKET_BYTES = pte_pkg::MAX_PACKET_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire pte_pkg::in_item_t  item,
  output logic                    empty,
  input  wire logic               pop,
  output pte_pkg::out_item_t      result
);

  import pte_pkg::*;

  localparam int OUT_SUM_W = OUT_CNT_W + 1;
  localparam logic [MID_CNT_W-1:0] MID_FULL_AT = MID_CNT_W'(MID_DEPTH - 1);

  logic                 accept;
  logic                 mid_push;
  pkt_t                 mid_in;
  pkt_t                 mid_head;
  logic [MID_CNT_W-1:0] mid_count;
  logic                 issue;
  logic                 room;

  logic                 bk_valid;
  logic [REL_W-1:0]     bk_rel;
  meta_t                bk_meta;

  logic                 done;
  out_item_t            sc_result;
  logic [OUT_CNT_W-1:0] out_count;
  logic [OUT_CNT_W-1:0] inflight;
  logic                 out_pop;

  assign full   = (mid_count >= MID_FULL_AT);
  assign accept = push && !full;

  pte_front #(
    .MAX_PACKET_BYTES(MAX_PACKET_BYTES)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (accept),
    .item  (item),
    .valid (mid_push),
    .entry (mid_in)
  );

  pte_queue #(
    .Width($bits(pkt_t)),
    .Depth(MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .pop   (issue),
    .rdata (mid_head),
    .count (mid_count)
  );

  assign room  = (OUT_SUM_W'(out_count) + OUT_SUM_W'(inflight)) < OUT_SUM_W'(OUT_DEPTH);
  assign issue = (mid_count != '0) && (mid_head.clr || room);

  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= '0;
    end else if ((issue && !mid_head.clr) && !done) begin
      inflight <= inflight + OUT_CNT_W'(1);
    end else if (!(issue && !mid_head.clr) && done) begin
      inflight <= inflight - OUT_CNT_W'(1);
    end
  end

  pte_unwrap u_unwrap (
    .clk   (clk),
    .rst   (rst),
    .issue (issue),
    .entry (mid_head),
    .valid (bk_valid),
    .rel   (bk_rel),
    .meta  (bk_meta)
  );

  pte_scale u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (bk_valid),
    .rel    (bk_rel),
    .meta   (bk_meta),
    .done   (done),
    .result (sc_result)
  );

  assign empty   = (out_count == '0);
  assign out_pop = pop && !empty;

  pte_queue #(
    .Width($bits(out_item_t)),
    .Depth(OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (done),
    .wdata (sc_result),
    .pop   (out_pop),
    .rdata (result),
    .count (out_count)
  );

`ifndef SYNTHESIS
  a_mid_no_overflow: assert property (@(posedge clk) disable iff (rst)
    mid_push |-> (mid_count < MID_CNT_W'(MID_DEPTH)))
    else $error("middle queue written while full");

  a_out_credit: assert property (@(posedge clk) disable iff (rst)
    (OUT_SUM_W'(out_count) + OUT_SUM_W'(inflight)) <= OUT_SUM_W'(OUT_DEPTH))
    else $error("output credits exceeded");

  a_out_no_overflow: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_count < OUT_CNT_W'(OUT_DEPTH)))
    else $error("output queue written while full");

  a_clear_silent: assert property (@(posedge clk) disable iff (rst)
    (issue && mid_head.clr) |-> ##2 !bk_valid)
    else $error("clear produced a back-end item");
`endif

endmodule

`default_nettype wire
